// ===== rtl/core/asvc_pkg.sv =====
`timescale 1ns / 1ps
// asvc_pkg: shared types, widths and codes for the air spring valve controller
// no dependencies; used by every module under rtl/core

package asvc_pkg;

	localparam int ADC_BITS    = 12;
	localparam int OHM_W       = 10;
	localparam int P_W         = 14;
	localparam int CFG_W       = 14;
	localparam int CFG_IDX_W   = 3;
	localparam int REQ_W       = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam int NUM_W = OHM_W + ADC_BITS;
	localparam int TOP_W = NUM_W + P_W;

	// rail thresholds: raw*330 >= 329*F and raw*330 <= F
	localparam int ADC_FULL = (1 << ADC_BITS) - 1;
	localparam int HI_RAIL  = (329 * ADC_FULL + 329) / 330;
	localparam int LO_RAIL  = ADC_FULL / 330;

	localparam logic [REQ_W-1:0] REQ_SAMPLE  = 3'd0;
	localparam logic [REQ_W-1:0] REQ_INFLATE = 3'd1;
	localparam logic [REQ_W-1:0] REQ_DEFLATE = 3'd2;
	localparam logic [REQ_W-1:0] REQ_HOLD    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_TARGET  = 3'd4;
	localparam logic [REQ_W-1:0] REQ_START   = 3'd5;

	localparam logic [CFG_IDX_W-1:0] CFG_DIVIDER_REF = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_LOW  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_HIGH = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FULL_SCALE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BAG_MAX     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_BAG_MIN     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE   = 3'd6;

	typedef enum logic [2:0] {
		OP_SAMPLE  = 3'd0,
		OP_INFLATE = 3'd1,
		OP_DEFLATE = 3'd2,
		OP_HOLD    = 3'd3,
		OP_TARGET  = 3'd4,
		OP_START   = 3'd5,
		OP_NONE    = 3'd6
	} op_t;

	typedef enum logic [1:0] {
		MODE_HOLD    = 2'd0,
		MODE_INFLATE = 2'd1,
		MODE_DEFLATE = 2'd2
	} mode_t;

	typedef struct packed {
		logic [REQ_W-1:0]    req_type;
		logic [ADC_BITS-1:0] adc_sample;
		logic [P_W-1:0]      target_request;
	} in_t;

	typedef struct packed {
		logic           inflate_open;
		logic           deflate_open;
		logic [P_W-1:0] pressure_now;
		logic [P_W-1:0] target_now;
		logic           at_target;
	} out_t;

	typedef struct packed {
		op_t                 op;
		logic                conv;
		logic [ADC_BITS-1:0] adc_sample;
		logic [P_W-1:0]      target_request;
	} cmd_t;

	typedef struct packed {
		logic [OHM_W-1:0] divider_ref_ohms;
		logic [OHM_W-1:0] sensor_low_ohms;
		logic [OHM_W-1:0] sensor_high_ohms;
		logic [P_W-1:0]   full_scale_pressure;
		logic [P_W-1:0]   bag_max_pressure;
		logic [P_W-1:0]   bag_min_pressure;
		logic [P_W-1:0]   target_tolerance;
	} cfg_t;

endpackage

// ===== rtl/core/asvc_front.sv =====
`timescale 1ns / 1ps
// asvc_front: accepts transactions, decodes the request code and queues commands
// depends on asvc_pkg

module asvc_front #(
	parameter int DEPTH = asvc_pkg::QUEUE_DEPTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  asvc_pkg::in_t       req,
	output logic                q_valid,
	input  logic                q_pop,
	output asvc_pkg::cmd_t      q_cmd
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	asvc_pkg::cmd_t   mem_q [DEPTH];
	asvc_pkg::cmd_t   dec;
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		case (req.req_type)
			asvc_pkg::REQ_SAMPLE:  dec.op = asvc_pkg::OP_SAMPLE;
			asvc_pkg::REQ_INFLATE: dec.op = asvc_pkg::OP_INFLATE;
			asvc_pkg::REQ_DEFLATE: dec.op = asvc_pkg::OP_DEFLATE;
			asvc_pkg::REQ_HOLD:    dec.op = asvc_pkg::OP_HOLD;
			asvc_pkg::REQ_TARGET:  dec.op = asvc_pkg::OP_TARGET;
			asvc_pkg::REQ_START:   dec.op = asvc_pkg::OP_START;
			default:               dec.op = asvc_pkg::OP_NONE;
		endcase
		dec.conv           = req.req_type inside {asvc_pkg::REQ_SAMPLE, asvc_pkg::REQ_START};
		dec.adc_sample     = req.adc_sample;
		dec.target_request = req.target_request;
	end

	assign full    = count_q == CNT_W'(DEPTH);
	assign q_valid = count_q != '0;
	assign q_cmd   = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/core/asvc_conv.sv =====
`timescale 1ns / 1ps
// asvc_conv: converts a raw sample to pressure through the divider formula
// uses registered multipliers and a restoring divider; depends on asvc_pkg

module asvc_conv (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [asvc_pkg::ADC_BITS-1:0] raw,
	input  asvc_pkg::cfg_t                cfg,
	output logic                          done,
	output logic [asvc_pkg::P_W-1:0]      pressure
);

	localparam int ADC_W   = asvc_pkg::ADC_BITS;
	localparam int P_W     = asvc_pkg::P_W;
	localparam int NUM_W   = asvc_pkg::NUM_W;
	localparam int TOP_W   = asvc_pkg::TOP_W;
	localparam int CNT_W   = $clog2(P_W);
	localparam int OHM_W_L = asvc_pkg::OHM_W;

	typedef enum logic [4:0] {
		C_IDLE  = 5'b00001,
		C_MUL   = 5'b00010,
		C_CMP   = 5'b00100,
		C_SCALE = 5'b01000,
		C_DIV   = 5'b10000
	} cstate_t;

	cstate_t          state_q;
	logic [ADC_W-1:0] raw_q;
	logic [NUM_W-1:0] num_q;
	logic [NUM_W-1:0] lorem_q;
	logic [NUM_W-1:0] hirem_q;
	logic [NUM_W-1:0] bot_q;
	logic [NUM_W-1:0] diff_q;
	logic [TOP_W-1:0] r_q;
	logic [TOP_W-1:0] dsr_q;
	logic [P_W-1:0]   quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             done_q;
	logic [P_W-1:0]   pressure_q;
	logic [ADC_W-1:0] rem;
	logic [OHM_W_L-1:0] span;
	logic             ge;
	logic             early;

	assign rem  = ADC_W'(asvc_pkg::ADC_FULL) - raw_q;
	assign span = cfg.sensor_high_ohms - cfg.sensor_low_ohms;
	assign ge   = r_q >= dsr_q;

	// result known without the divider
	assign early = cfg.sensor_high_ohms <= cfg.sensor_low_ohms ||
		raw_q >= ADC_W'(asvc_pkg::HI_RAIL) || raw_q <= ADC_W'(asvc_pkg::LO_RAIL) ||
		num_q <= lorem_q || num_q >= hirem_q;

	assign done     = done_q;
	assign pressure = pressure_q;

	always_ff @(posedge clk) begin
		case (state_q)
			C_IDLE: begin
				if (start) begin
					raw_q <= raw;
				end
			end
			C_MUL: begin
				num_q   <= NUM_W'(cfg.divider_ref_ohms) * NUM_W'(raw_q);
				lorem_q <= NUM_W'(cfg.sensor_low_ohms) * NUM_W'(rem);
				hirem_q <= NUM_W'(cfg.sensor_high_ohms) * NUM_W'(rem);
				bot_q   <= NUM_W'(span) * NUM_W'(rem);
			end
			C_CMP: begin
				diff_q <= num_q - lorem_q;
			end
			C_SCALE: begin
				r_q   <= TOP_W'(diff_q) * TOP_W'(cfg.full_scale_pressure);
				dsr_q <= TOP_W'(bot_q) << (P_W - 1);
			end
			C_DIV: begin
				if (ge) begin
					r_q <= r_q - dsr_q;
				end
				dsr_q <= dsr_q >> 1;
				quo_q <= {quo_q[P_W-2:0], ge};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= C_IDLE;
			cnt_q      <= '0;
			done_q     <= 1'b0;
			pressure_q <= '0;
		end else begin
			done_q <= (state_q == C_CMP && early) || (state_q == C_DIV && cnt_q == '0);
			case (state_q)
				C_IDLE: begin
					if (start) begin
						state_q <= C_MUL;
					end
				end
				C_MUL: begin
					state_q <= C_CMP;
				end
				C_CMP: begin
					if (cfg.sensor_high_ohms <= cfg.sensor_low_ohms) begin
						pressure_q <= '0;
						state_q    <= C_IDLE;
					end else if (raw_q >= ADC_W'(asvc_pkg::HI_RAIL)) begin
						pressure_q <= cfg.full_scale_pressure;
						state_q    <= C_IDLE;
					end else if (raw_q <= ADC_W'(asvc_pkg::LO_RAIL) || num_q <= lorem_q) begin
						pressure_q <= '0;
						state_q    <= C_IDLE;
					end else if (num_q >= hirem_q) begin
						pressure_q <= cfg.full_scale_pressure;
						state_q    <= C_IDLE;
					end else begin
						state_q <= C_SCALE;
					end
				end
				C_SCALE: begin
					cnt_q   <= CNT_W'(P_W - 1);
					state_q <= C_DIV;
				end
				C_DIV: begin
					if (cnt_q == '0) begin
						pressure_q <= {quo_q[P_W-2:0], ge};
						state_q    <= C_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/asvc_back.sv =====
`timescale 1ns / 1ps
// asvc_back: executes queued commands, holds valve mode, pressure and target
// instantiates asvc_conv and holds the result register; depends on asvc_pkg

module asvc_back (
	input  logic               clk,
	input  logic               arst_n,
	input  asvc_pkg::cfg_t     cfg,
	input  logic               q_valid,
	output logic               q_pop,
	input  asvc_pkg::cmd_t     q_cmd,
	output logic               empty,
	input  logic               pop,
	output asvc_pkg::out_t     res
);

	localparam int P_W = asvc_pkg::P_W;

	typedef enum logic [3:0] {
		B_IDLE = 4'b0001,
		B_EXEC = 4'b0010,
		B_CONV = 4'b0100,
		B_EMIT = 4'b1000
	} bstate_t;

	bstate_t          state_q;
	asvc_pkg::cmd_t   cmd_q;
	asvc_pkg::mode_t  mode_q;
	logic [P_W-1:0]   pressure_q;
	logic [P_W-1:0]   target_q;
	asvc_pkg::out_t   res_q;
	logic             res_valid_q;
	logic             conv_start;
	logic             conv_done;
	logic [P_W-1:0]   conv_p;
	logic [P_W-1:0]   want_lo;
	logic [P_W-1:0]   want;
	logic [P_W-1:0]   diff;
	logic             slot_free;
	asvc_pkg::out_t   res_d;

	asvc_conv u_conv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (conv_start),
		.raw      (cmd_q.adc_sample),
		.cfg      (cfg),
		.done     (conv_done),
		.pressure (conv_p)
	);

	assign q_pop      = state_q == B_IDLE && q_valid;
	assign conv_start = state_q == B_EXEC && cmd_q.conv;
	assign slot_free  = !res_valid_q || pop;
	assign empty      = !res_valid_q;
	assign res        = res_q;

	// floor first, ceiling second
	assign want_lo = (cmd_q.target_request < cfg.bag_min_pressure) ?
		cfg.bag_min_pressure : cmd_q.target_request;
	assign want    = (want_lo > cfg.bag_max_pressure) ? cfg.bag_max_pressure : want_lo;

	assign diff = (pressure_q >= target_q) ? pressure_q - target_q : target_q - pressure_q;

	always_comb begin
		res_d.inflate_open = mode_q == asvc_pkg::MODE_INFLATE;
		res_d.deflate_open = mode_q == asvc_pkg::MODE_DEFLATE;
		res_d.pressure_now = pressure_q;
		res_d.target_now   = target_q;
		res_d.at_target    = diff <= cfg.target_tolerance;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
		if (state_q == B_EMIT && slot_free) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			mode_q      <= asvc_pkg::MODE_HOLD;
			pressure_q  <= '0;
			target_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (state_q == B_EMIT && slot_free) begin
				res_valid_q <= 1'b1;
			end else if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_EXEC;
					end
				end
				B_EXEC: begin
					if (cmd_q.conv) begin
						state_q <= B_CONV;
					end else begin
						state_q <= B_EMIT;
						case (cmd_q.op)
							asvc_pkg::OP_INFLATE: begin
								if (pressure_q < cfg.bag_max_pressure) begin
									mode_q <= asvc_pkg::MODE_INFLATE;
								end
							end
							asvc_pkg::OP_DEFLATE: mode_q   <= asvc_pkg::MODE_DEFLATE;
							asvc_pkg::OP_HOLD:    mode_q   <= asvc_pkg::MODE_HOLD;
							asvc_pkg::OP_TARGET:  target_q <= want;
							default: begin
							end
						endcase
					end
				end
				B_CONV: begin
					if (conv_done) begin
						state_q    <= B_EMIT;
						pressure_q <= conv_p;
						if (cmd_q.op == asvc_pkg::OP_START) begin
							mode_q   <= asvc_pkg::MODE_HOLD;
							target_q <= conv_p;
						end else if (mode_q == asvc_pkg::MODE_INFLATE &&
							conv_p >= cfg.bag_max_pressure) begin
							mode_q <= asvc_pkg::MODE_HOLD;
						end else if (mode_q == asvc_pkg::MODE_DEFLATE &&
							conv_p <= cfg.bag_min_pressure) begin
							mode_q <= asvc_pkg::MODE_HOLD;
						end
					end
				end
				B_EMIT: begin
					if (slot_free) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/air_spring_valve_controller_unit.sv =====
`timescale 1ns / 1ps
// air_spring_valve_controller_unit: top level with configuration registers
// instantiates asvc_front and asvc_back; depends on asvc_pkg

// Each request transaction yields exactly one result transaction showing valve
// drive, pressure, target and the at-target flag. Requests enter a command
// queue (QUEUE_DEPTH entries) and are executed one at a time. Inflate,
// deflate, hold, set target and unused codes go from the execute state to the
// emit state. Sample and start run the pressure conversion: four registered
// products, a compare, a scaling product and a 14-step restoring divider. A reading
// on a rail or outside the sensor range skips the divider. A result that is not
// popped stalls execution and then the input. Write the configuration registers
// only while no transaction is outstanding.

module air_spring_valve_controller_unit #(
	parameter int QUEUE_DEPTH = asvc_pkg::QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  asvc_pkg::in_t                  req,
	output logic                           empty,
	input  logic                           pop,
	output asvc_pkg::out_t                 res,
	input  logic                           cfg_write,
	input  logic [asvc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [asvc_pkg::CFG_W-1:0]     cfg_data
);

	localparam int OHM_W = asvc_pkg::OHM_W;
	localparam int P_W   = asvc_pkg::P_W;

	asvc_pkg::cfg_t cfg_q;
	asvc_pkg::cmd_t q_cmd;
	logic           q_valid;
	logic           q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.divider_ref_ohms    <= OHM_W'(100);
			cfg_q.sensor_low_ohms     <= OHM_W'(10);
			cfg_q.sensor_high_ohms    <= OHM_W'(180);
			cfg_q.full_scale_pressure <= P_W'(15000);
			cfg_q.bag_max_pressure    <= P_W'(15000);
			cfg_q.bag_min_pressure    <= '0;
			cfg_q.target_tolerance    <= P_W'(100);
		end else if (cfg_write) begin
			case (cfg_index)
				asvc_pkg::CFG_DIVIDER_REF: cfg_q.divider_ref_ohms    <= cfg_data[OHM_W-1:0];
				asvc_pkg::CFG_SENSOR_LOW:  cfg_q.sensor_low_ohms     <= cfg_data[OHM_W-1:0];
				asvc_pkg::CFG_SENSOR_HIGH: cfg_q.sensor_high_ohms    <= cfg_data[OHM_W-1:0];
				asvc_pkg::CFG_FULL_SCALE:  cfg_q.full_scale_pressure <= cfg_data[P_W-1:0];
				asvc_pkg::CFG_BAG_MAX:     cfg_q.bag_max_pressure    <= cfg_data[P_W-1:0];
				asvc_pkg::CFG_BAG_MIN:     cfg_q.bag_min_pressure    <= cfg_data[P_W-1:0];
				asvc_pkg::CFG_TOLERANCE:   cfg_q.target_tolerance    <= cfg_data[P_W-1:0];
				default: begin
				end
			endcase
		end
	end

	asvc_front #(
		.DEPTH (QUEUE_DEPTH)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.req     (req),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_cmd   (q_cmd)
	);

	asvc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.q_valid (q_valid),
		.q_pop   (q_pop),
		.q_cmd   (q_cmd),
		.empty   (empty),
		.pop     (pop),
		.res     (res)
	);

endmodule
